// ===== hdl/u8s_pkg.sv =====
`default_nettype none

package u8s_pkg;

    localparam logic [7:0] REP_B0 = 8'hEF;
    localparam logic [7:0] REP_B1 = 8'hBF;
    localparam logic [7:0] REP_B2 = 8'hBD;

    localparam logic [20:0] CP_MIN3    = 21'h000800;
    localparam logic [20:0] CP_MIN4    = 21'h010000;
    localparam logic [20:0] CP_SURR_LO = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI = 21'h00DFFF;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;

    typedef logic [7:0] t_byte;

    function automatic t_byte rep_byte(input logic [1:0] idx);
        t_byte b;
        case (idx)
            2'd0:    b = REP_B0;
            2'd1:    b = REP_B1;
            default: b = REP_B2;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/utf8_sanitizer.sv =====
`default_nettype none

// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_ready   | i_in_byte, i_in_last
// out     | output    | o_out_valid / i_out_ready | o_out_byte, o_out_last
//
// One byte is taken in ST_IDLE, then ST_EVAL judges the sequence at the head of the
// hold buffer, and ST_EMIT moves each result byte through the output register.
// After a sequence is emitted, ST_EVAL judges every further sequence the byte
// releases from the buffer (up to 3 such passes).
// A stalled output holds the sequencer in its emitting state.
// Reset empties the hold buffer and the output register.

module utf8_sanitizer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]      r_state;
    u8s_pkg::t_byte  r_buf [4];
    logic [2:0]      r_cnt;
    logic            r_last;
    logic            r_rep;
    logic [2:0]      r_len;
    logic [2:0]      r_k;
    logic [1:0]      r_idx;
    u8s_pkg::t_byte  r_ob;
    logic            r_ol;
    logic            r_ov;

    u8s_pkg::t_byte  n_buf [4];
    logic [2:0]      w_sh;
    logic [2:0]      w_need;
    logic [20:0]     w_cp;
    logic            w_cont_ok;
    logic            w_bad;
    logic            e_stop;
    logic            e_rep;
    logic [2:0]      e_len;
    logic [2:0]      e_k;
    logic            w_fin;
    logic [2:0]      w_rem;
    logic            w_load;
    u8s_pkg::t_byte  w_ob;

    // Judge the sequence that starts at the head of the buffer.
    always_comb begin
        w_need    = 3'd0;
        w_cp      = 21'd0;
        w_cont_ok = 1'b0;
        w_bad     = 1'b1;
        e_stop    = 1'b0;
        e_rep     = 1'b1;
        e_len     = 3'd3;
        e_k       = 3'd1;
        if (r_buf[0] inside {[8'h00:8'h7F]}) begin
            e_rep = 1'b0;
            e_len = 3'd1;
        end else if (r_buf[0] inside {[8'hC2:8'hDF]}) begin
            w_need = 3'd2;
        end else if (r_buf[0] inside {[8'hE0:8'hEF]}) begin
            w_need = 3'd3;
        end else if (r_buf[0] inside {[8'hF0:8'hF7]}) begin
            w_need = 3'd4;
        end
        case (w_need)
            3'd2:    w_cp = {10'd0, r_buf[0][4:0], r_buf[1][5:0]};
            3'd3:    w_cp = {5'd0, r_buf[0][3:0], r_buf[1][5:0], r_buf[2][5:0]};
            3'd4:    w_cp = {r_buf[0][2:0], r_buf[1][5:0], r_buf[2][5:0], r_buf[3][5:0]};
            default: w_cp = 21'd0;
        endcase
        w_cont_ok = (r_buf[1][7:6] == 2'b10)
                  && ((w_need < 3'd3) || (r_buf[2][7:6] == 2'b10))
                  && ((w_need < 3'd4) || (r_buf[3][7:6] == 2'b10));
        w_bad = ((w_need == 3'd3) && (w_cp < u8s_pkg::CP_MIN3))
              || ((w_need == 3'd4) && (w_cp < u8s_pkg::CP_MIN4))
              || ((w_cp >= u8s_pkg::CP_SURR_LO) && (w_cp <= u8s_pkg::CP_SURR_HI))
              || (w_cp > u8s_pkg::CP_MAX);
        if (w_need != 3'd0) begin
            if (r_cnt < w_need) begin
                if (r_last) begin
                    e_k = r_cnt;
                end else begin
                    e_stop = 1'b1;
                end
            end else if (w_cont_ok && !w_bad) begin
                e_rep = 1'b0;
                e_len = w_need;
                e_k   = w_need;
            end
        end
    end

    always_comb begin
        w_sh = 3'd0;
        for (int i = 0; i < 4; i++) begin
            w_sh = 3'(i) + r_k;
            n_buf[i] = (w_sh < 3'd4) ? r_buf[w_sh[1:0]] : r_buf[i];
        end
    end

    assign w_fin  = ((3'(r_idx) + 3'd1) == r_len);
    assign w_rem  = r_cnt - r_k;
    assign w_load = !r_ov || i_out_ready;
    assign w_ob   = r_rep ? u8s_pkg::rep_byte(r_idx) : r_buf[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 3'd0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_out_ready && (r_state != ST_EMIT)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_buf[r_cnt[1:0]] <= i_in_byte;
                        r_cnt             <= r_cnt + 3'd1;
                        r_last            <= i_in_last;
                        r_state           <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (e_stop || (r_cnt == 3'd0)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_rep   <= e_rep;
                        r_len   <= e_len;
                        r_k     <= e_k;
                        r_idx   <= 2'd0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        r_ov  <= 1'b1;
                        r_ob  <= w_ob;
                        r_ol  <= w_fin && r_last && (w_rem == 3'd0);
                        r_idx <= r_idx + 2'd1;
                        if (w_fin) begin
                            for (int i = 0; i < 4; i++) begin
                                r_buf[i] <= n_buf[i];
                            end
                            r_cnt   <= w_rem;
                            r_state <= (w_rem == 3'd0) ? ST_IDLE : ST_EVAL;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_out_last  = r_ol;

endmodule

`default_nettype wire

// ===== hdl/u8s_checker.sv =====
`default_nettype none

module u8s_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic [7:0] i_in_byte,
    input wire logic       i_in_last,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_out_last
);

    // A stalled output beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_byte)
                                           && $stable(o_out_last)))
        else $error("output beat changed while stalled");

    // The sequencer is not ready in the cycle after it takes a byte.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken on consecutive cycles");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A waiting input beat keeps its payload until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> (i_in_valid && $stable(i_in_byte)
                                         && $stable(i_in_last)))
        else $error("input beat changed while waiting");

    // A byte taken while the output is empty is judged before any output beat can appear.
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> !o_out_valid)
        else $error("output beat without a judging cycle");

endmodule

bind utf8_sanitizer u8s_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_byte   (i_in_byte),
    .i_in_last   (i_in_last),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_byte  (o_out_byte),
    .o_out_last  (o_out_last)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT = 22;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    t_out_beat   sanitized_q[$];
    logic [7:0]  text_q[$];
    logic [7:0]  held[4];
    int          held_n = 0;
    int          errors = 0;
    bit          steady = 1'b0;
    int unsigned cycles = 0;

    utf8_sanitizer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void push_out(input logic [7:0] b);
        t_out_beat beat;
        beat.data = b;
        beat.last = 1'b0;
        sanitized_q = {sanitized_q, beat};
    endfunction

    function automatic void add_text(input logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    function automatic void push_replacement();
        push_out(u8s_pkg::REP_B0);
        push_out(u8s_pkg::REP_B1);
        push_out(u8s_pkg::REP_B2);
    endfunction

    // Updates the held sequence and queues every byte the new input byte releases.
    function automatic void sanitize_byte(input logic [7:0] b, input logic l);
        logic [7:0]  win[4];
        logic [7:0]  lead;
        logic [20:0] cp;
        logic        ok;
        logic        stop;
        t_out_beat   tail;
        int          cnt;
        int          p;
        int          need;
        int          j;
        int          first;

        first = sanitized_q.size();
        cnt = held_n;
        for (j = 0; j < cnt; j++) begin
            win[j] = held[j];
        end
        win[cnt] = b;
        cnt++;
        p = 0;
        stop = 1'b0;
        while (p < cnt && !stop) begin
            lead = win[p];
            need = 0;
            if (lead[7] == 1'b0) begin
                push_out(lead);
                p++;
            end else begin
                if (lead[7:5] == 3'b110) begin
                    need = (lead[4:1] == 4'd0) ? 0 : 2;
                    cp = {16'd0, lead[4:0]};
                end else if (lead[7:4] == 4'b1110) begin
                    need = 3;
                    cp = {17'd0, lead[3:0]};
                end else if (lead[7:3] == 5'b11110) begin
                    need = 4;
                    cp = {18'd0, lead[2:0]};
                end
                if (need == 0) begin
                    push_replacement();
                    p++;
                end else if (cnt - p < need) begin
                    if (l) begin
                        push_replacement();
                        p = cnt;
                    end
                    stop = 1'b1;
                end else begin
                    ok = 1'b1;
                    for (j = 1; j < need; j++) begin
                        if (win[p + j][7:6] != 2'b10) begin
                            ok = 1'b0;
                        end else begin
                            cp = (cp << 6) | {15'd0, win[p + j][5:0]};
                        end
                    end
                    if (ok && ((need == 3 && cp < u8s_pkg::CP_MIN3) ||
                               (need == 4 && cp < u8s_pkg::CP_MIN4) ||
                               (cp >= u8s_pkg::CP_SURR_LO && cp <= u8s_pkg::CP_SURR_HI) ||
                               cp > u8s_pkg::CP_MAX)) begin
                        ok = 1'b0;
                    end
                    if (!ok) begin
                        push_replacement();
                        p++;
                    end else begin
                        for (j = 0; j < need; j++) begin
                            push_out(win[p + j]);
                        end
                        p += need;
                    end
                end
            end
        end

        if (l || p >= cnt) begin
            held_n = 0;
        end else begin
            for (j = 0; j < cnt - p; j++) begin
                held[j] = win[p + j];
            end
            held_n = cnt - p;
        end

        if (l && sanitized_q.size() > first) begin
            tail = sanitized_q[sanitized_q.size() - 1];
            tail.last = 1'b1;
            sanitized_q[sanitized_q.size() - 1] = tail;
        end
    endfunction

    // Called at a rising edge; returns at the edge that accepts the beat, valid still high.
    task automatic send_byte(input logic [7:0] b, input logic l);
        logic taken;

        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= l;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end
        sanitize_byte(b, l);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (sanitized_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic add_unit();
        int          kind;
        logic [7:0]  lead;
        logic [7:0]  lo;
        logic [7:0]  hi;

        kind = $urandom_range(99);
        lo = 8'h80;
        hi = 8'hBF;
        if (kind < 28) begin
            add_text(8'($urandom_range(8'h7F)));
        end else if (kind < 43) begin
            add_text(8'($urandom_range(8'hDF, 8'hC2)));
            add_text(8'($urandom_range(8'hBF, 8'h80)));
        end else if (kind < 60) begin
            lead = 8'($urandom_range(8'hEF, 8'hE0));
            if (lead == 8'hE0) lo = 8'hA0;
            if (lead == 8'hED) hi = 8'h9F;
            add_text(lead);
            add_text(8'($urandom_range(hi, lo)));
            add_text(8'($urandom_range(8'hBF, 8'h80)));
        end else if (kind < 76) begin
            lead = 8'($urandom_range(8'hF4, 8'hF0));
            if (lead == 8'hF0) lo = 8'h90;
            if (lead == 8'hF4) hi = 8'h8F;
            add_text(lead);
            add_text(8'($urandom_range(hi, lo)));
            add_text(8'($urandom_range(8'hBF, 8'h80)));
            add_text(8'($urandom_range(8'hBF, 8'h80)));
        end else if (kind < 87) begin
            add_text(8'($urandom_range(255)));
        end else begin
            add_text(8'($urandom_range(8'hF7, 8'hC0)));
            repeat ($urandom_range(2)) add_text(8'($urandom_range(8'hBF, 8'h80)));
            add_text(8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_text(input int items);
        int count;
        int i;

        count = 0;
        while (count < items) begin
            text_q.delete();
            repeat ($urandom_range(6, 1)) add_unit();
            for (i = 0; i < text_q.size(); i++) begin
                send_byte(text_q[i], i == text_q.size() - 1);
            end
            count += text_q.size();
        end
    endtask

    task automatic test_extremes();
        send_byte(8'h00, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_valid_forms();
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    task automatic test_bad_units();
        send_byte(8'hC0, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF5, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_truncated_end();
        send_byte(8'hF0, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b1);
    endtask

    task automatic test_steady_stream(input int items);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        steady = 1'b1;
        @(posedge i_clk);
        test_random_text(items);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        steady = 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sanitized_q.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: expected none, actual byte %h last %b",
                         $time, o_out_byte, o_out_last);
            end else begin
                want = sanitized_q.pop_front();
                if (o_out_byte !== want.data) begin
                    errors++;
                    $display("%0t out_byte mismatch: expected %h, actual %h",
                             $time, want.data, o_out_byte);
                end
                if (o_out_last !== want.last) begin
                    errors++;
                    $display("%0t out_last mismatch: expected %b, actual %b",
                             $time, want.last, o_out_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_valid_forms();
        test_bad_units();
        test_truncated_end();
        test_random_text(110);
        wait_for_drain();
        test_random_text(50);
        test_steady_stream(40);
        test_random_text(30);
        wait_for_drain();
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
